/* rtl/core/pjq_pkg.sv */
package pjq_pkg;

  // Default capacity of the queue in entries
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_POPPED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;       // capture a new result
    logic       do_insert;  // insert the request into the sorted row
    logic       do_pop;     // shift the row toward the head
    logic [1:0] code;       // status of the result being captured
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

/* rtl/core/pjq_ctrl.sv */
module pjq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           kind,
  output logic           out_valid,
  input  logic           out_stall,
  input  pjq_pkg::stat_t stat,
  output pjq_pkg::cmd_t  cmd
);
  import pjq_pkg::*;

  localparam logic S_IDLE = 1'b0;  // result register empty
  localparam logic S_HOLD = 1'b1;  // result register holds a result

  logic state;
  logic state_next;
  logic accept;

  assign in_stall  = (state == S_HOLD) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == S_HOLD);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall && !accept) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the accepted item into a datapath command
  always_comb begin
    cmd.load      = accept;
    cmd.do_insert = 1'b0;
    cmd.do_pop    = 1'b0;
    cmd.code      = ST_INSERTED;
    if (kind == KIND_INSERT) begin
      if (stat.full) begin
        cmd.code = ST_FULL;
      end else begin
        cmd.code      = ST_INSERTED;
        cmd.do_insert = accept;
      end
    end else begin
      if (stat.empty) begin
        cmd.code = ST_EMPTY;
      end else begin
        cmd.code   = ST_POPPED;
        cmd.do_pop = accept;
      end
    end
  end

endmodule

/* rtl/core/pjq_dp.sv */
module pjq_dp #(
  parameter int QUEUE_DEPTH = pjq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  pjq_pkg::cmd_t  cmd,
  output pjq_pkg::stat_t stat,
  input  logic [7:0]     priority_req,
  input  logic [15:0]    job_handle,
  output logic [1:0]     status,
  output logic [15:0]    out_handle,
  output logic [7:0]     out_priority
);
  import pjq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]      slot_priority [QUEUE_DEPTH];
  logic [15:0]     slot_handle   [QUEUE_DEPTH];
  logic [CW-1:0]   occupancy;
  logic [QUEUE_DEPTH-1:0] take;
  logic [QUEUE_DEPTH-1:0] take_ahead;
  logic [7:0]      ahead_priority  [QUEUE_DEPTH];
  logic [15:0]     ahead_handle    [QUEUE_DEPTH];
  logic [7:0]      behind_priority [QUEUE_DEPTH];
  logic [15:0]     behind_handle   [QUEUE_DEPTH];

  assign stat.full  = (occupancy == CW'(QUEUE_DEPTH));
  assign stat.empty = (occupancy == '0);

  // A cell takes part in the insert when it is free or holds a strictly lower
  // priority; the row is sorted, so these cells form a run up to the tail.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      take[i] = (CW'(i) >= occupancy) || (slot_priority[i] < priority_req);
    end
  end

  // Neighbor views of each cell: the one toward the head and the one toward
  // the tail. The head has no cell ahead; the tail keeps its own entry.
  always_comb begin
    take_ahead                     = {take[QUEUE_DEPTH-2:0], 1'b0};
    ahead_priority[0]              = priority_req;
    ahead_handle[0]                = job_handle;
    behind_priority[QUEUE_DEPTH-1] = slot_priority[QUEUE_DEPTH-1];
    behind_handle[QUEUE_DEPTH-1]   = slot_handle[QUEUE_DEPTH-1];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      ahead_priority[i]    = slot_priority[i-1];
      ahead_handle[i]      = slot_handle[i-1];
      behind_priority[i-1] = slot_priority[i];
      behind_handle[i-1]   = slot_handle[i];
    end
  end

  // First cell of the run takes the request, the rest shift toward the tail
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.do_insert) begin
        if (take[i] && !take_ahead[i]) begin
          slot_priority[i] <= priority_req;
          slot_handle[i]   <= job_handle;
        end else if (take[i]) begin
          slot_priority[i] <= ahead_priority[i];
          slot_handle[i]   <= ahead_handle[i];
        end
      end else if (cmd.do_pop) begin
        slot_priority[i] <= behind_priority[i];
        slot_handle[i]   <= behind_handle[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.do_insert) begin
      occupancy <= occupancy + CW'(1);
    end else if (cmd.do_pop) begin
      occupancy <= occupancy - CW'(1);
    end
  end

  // Result register: head fields only for a pop, zero otherwise
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status <= cmd.code;
      if (cmd.code == ST_POPPED) begin
        out_handle   <= slot_handle[0];
        out_priority <= slot_priority[0];
      end else begin
        out_handle   <= '0;
        out_priority <= '0;
      end
    end
  end

endmodule

/* rtl/core/priority_job_queue_unit.sv */
// Sorted priority queue of job requests.
//
// Input channel (in_valid / in_stall): kind selects insert or pop; an insert
// carries priority_req and job_handle. An item transfers at a rising edge
// with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one result per item, with status
// (inserted, dropped because full, popped, empty) and, for a pop, the head
// job's out_handle and out_priority; both fields are zero otherwise.
// Latency: the result is presented in the cycle after the input transfer.
// Throughput: one item per cycle unless stalled. The queue is a row of
// QUEUE_DEPTH cells that all compare against the new priority at once and
// shift in the same cycle, so insert and pop each take one update of that row.
// Entries leave highest priority first, first in first out among equals.
// Reset empties the queue and the result register; no clearing pass.
// When the receiver stalls, the result is held and in_stall rises, so no
// new item transfers until the held result leaves.
module priority_job_queue_unit #(
  parameter int QUEUE_DEPTH = pjq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  priority_req,
  input  logic [15:0] job_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] out_handle,
  output logic [7:0]  out_priority
);
  import pjq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: tracks the result register and decodes each transfer
  pjq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: sorted cell row, occupancy count and result register
  pjq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .priority_req (priority_req),
    .job_handle   (job_handle),
    .status       (status),
    .out_handle   (out_handle),
    .out_priority (out_priority)
  );

endmodule

/* rtl/core/pjq_checker.sv */
module pjq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] out_handle,
  input logic [7:0]  out_priority
);
  import pjq_pkg::*;

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Every transfer in yields a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result after input transfer");

  // A held result blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input open while result is held");

  // Only a pop carries job fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_POPPED)) |-> (out_handle == '0 && out_priority == '0))
    else $error("nonzero job fields without pop");

  // A stalled result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(status) && $stable(out_handle) && $stable(out_priority)))
    else $error("stalled result changed");

endmodule

bind priority_job_queue_unit pjq_checker u_pjq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .out_handle   (out_handle),
  .out_priority (out_priority)
);
